FILE: sv/elt_pkg.sv
`default_nettype none

package elt_pkg;

	localparam int POSITION_BITS_DEF = 16;

	localparam int KIND_W = 6;
	localparam int ERR_W  = 2;
	localparam int MODE_W = 4;
	localparam int OP_N   = 6;

	// Lexer modes. The six pending-operator modes follow M_OP in op_first order.
	localparam logic [MODE_W-1:0] M_IDLE  = 4'd0;
	localparam logic [MODE_W-1:0] M_IDENT = 4'd1;
	localparam logic [MODE_W-1:0] M_NUM   = 4'd2;
	localparam logic [MODE_W-1:0] M_STR   = 4'd3;
	localparam logic [MODE_W-1:0] M_ESC   = 4'd4;
	localparam logic [MODE_W-1:0] M_OP    = 4'd5;

	localparam logic [KIND_W-1:0] K_ILLEGAL = 6'd0;
	localparam logic [KIND_W-1:0] K_END     = 6'd1;
	localparam logic [KIND_W-1:0] K_NEWLINE = 6'd2;
	localparam logic [KIND_W-1:0] K_PLUS    = 6'd3;
	localparam logic [KIND_W-1:0] K_MINUS   = 6'd4;
	localparam logic [KIND_W-1:0] K_STAR    = 6'd5;
	localparam logic [KIND_W-1:0] K_SLASH   = 6'd6;
	localparam logic [KIND_W-1:0] K_PERCENT = 6'd7;
	localparam logic [KIND_W-1:0] K_CARET   = 6'd8;
	localparam logic [KIND_W-1:0] K_COMMA   = 6'd9;
	localparam logic [KIND_W-1:0] K_COLON   = 6'd10;
	localparam logic [KIND_W-1:0] K_AMP     = 6'd11;
	localparam logic [KIND_W-1:0] K_AND     = 6'd12;
	localparam logic [KIND_W-1:0] K_BAR     = 6'd13;
	localparam logic [KIND_W-1:0] K_OR      = 6'd14;
	localparam logic [KIND_W-1:0] K_ASSIGN  = 6'd15;
	localparam logic [KIND_W-1:0] K_EQ      = 6'd16;
	localparam logic [KIND_W-1:0] K_ARROW   = 6'd17;
	localparam logic [KIND_W-1:0] K_BANG    = 6'd18;
	localparam logic [KIND_W-1:0] K_NE      = 6'd19;
	localparam logic [KIND_W-1:0] K_LT      = 6'd20;
	localparam logic [KIND_W-1:0] K_LE      = 6'd21;
	localparam logic [KIND_W-1:0] K_GT      = 6'd22;
	localparam logic [KIND_W-1:0] K_GE      = 6'd23;
	localparam logic [KIND_W-1:0] K_LPAREN  = 6'd24;
	localparam logic [KIND_W-1:0] K_RPAREN  = 6'd25;
	localparam logic [KIND_W-1:0] K_LBRACK  = 6'd26;
	localparam logic [KIND_W-1:0] K_RBRACK  = 6'd27;
	localparam logic [KIND_W-1:0] K_LBRACE  = 6'd28;
	localparam logic [KIND_W-1:0] K_RBRACE  = 6'd29;
	localparam logic [KIND_W-1:0] K_STRING  = 6'd30;
	localparam logic [KIND_W-1:0] K_INT     = 6'd31;
	localparam logic [KIND_W-1:0] K_IDENT   = 6'd32;

	localparam logic [ERR_W-1:0] E_NONE        = 2'd0;
	localparam logic [ERR_W-1:0] E_ILLEGAL     = 2'd1;
	localparam logic [ERR_W-1:0] E_OPEN_STRING = 2'd2;

	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;

	localparam logic [2:0] OPI_EQUAL = 3'd2;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
		logic [KIND_W-1:0] k;
		unique case (c)
			8'h2B: k = K_PLUS;
			8'h2D: k = K_MINUS;
			8'h2A: k = K_STAR;
			8'h2F: k = K_SLASH;
			8'h25: k = K_PERCENT;
			8'h5E: k = K_CARET;
			8'h2C: k = K_COMMA;
			8'h3A: k = K_COLON;
			8'h28: k = K_LPAREN;
			8'h29: k = K_RPAREN;
			8'h5B: k = K_LBRACK;
			8'h5D: k = K_RBRACK;
			8'h7B: k = K_LBRACE;
			8'h7D: k = K_RBRACE;
			default: k = K_ILLEGAL;
		endcase
		return k;
	endfunction

	function automatic logic is_op_first(input logic [7:0] c);
		return c == CH_AMP || c == CH_BAR || c == CH_EQUAL || c == CH_BANG ||
			c == CH_LT || c == CH_GT;
	endfunction

	function automatic logic [2:0] op_index(input logic [7:0] c);
		logic [2:0] i;
		unique case (c)
			CH_AMP:   i = 3'd0;
			CH_BAR:   i = 3'd1;
			CH_EQUAL: i = 3'd2;
			CH_BANG:  i = 3'd3;
			CH_LT:    i = 3'd4;
			default:  i = 3'd5;
		endcase
		return i;
	endfunction

	function automatic logic [KIND_W-1:0] op_single(input logic [2:0] i);
		logic [KIND_W-1:0] k;
		unique case (i)
			3'd0:    k = K_AMP;
			3'd1:    k = K_BAR;
			3'd2:    k = K_ASSIGN;
			3'd3:    k = K_BANG;
			3'd4:    k = K_LT;
			default: k = K_GT;
		endcase
		return k;
	endfunction

	function automatic logic [7:0] op_second(input logic [2:0] i);
		logic [7:0] c;
		unique case (i)
			3'd0:    c = CH_AMP;
			3'd1:    c = CH_BAR;
			default: c = CH_EQUAL;
		endcase
		return c;
	endfunction

	function automatic logic [KIND_W-1:0] op_double(input logic [2:0] i);
		logic [KIND_W-1:0] k;
		unique case (i)
			3'd0:    k = K_AND;
			3'd1:    k = K_OR;
			3'd2:    k = K_EQ;
			3'd3:    k = K_NE;
			3'd4:    k = K_LE;
			default: k = K_GE;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

FILE: sv/elt_lexer.sv
`default_nettype none

module elt_lexer
	import elt_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEF,
	localparam int TokW = 4 * POSITION_BITS + KIND_W + ERR_W + 2
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire logic [7:0]      text_byte,
	input  wire logic            end_of_text,
	output logic      [TokW-1:0] tok0,
	output logic      [TokW-1:0] tok1,
	output logic      [1:0]      tok_count
);

	localparam int P = POSITION_BITS;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [P-1:0]      start;
		logic [P-1:0]      len;
		logic [P-1:0]      line;
		logic [P-1:0]      col;
		logic              opt;
		logic [ERR_W-1:0]  err;
		logic              last;
	} tok_t;

	logic [MODE_W-1:0] mode_q, mode_d;
	logic [P-1:0]      tso_q, tso_d;
	logic [P-1:0]      tsl_q, tsl_d;
	logic [P-1:0]      tsc_q, tsc_d;
	logic [P-1:0]      plen_q, plen_d;
	logic [P-1:0]      boff_q, boff_d;
	logic [P-1:0]      line_q, line_d;
	logic [P-1:0]      col_q, col_d;

	tok_t ta, tb, t0, t1;
	logic has_a, has_b, used, op_mode;
	logic [2:0] oi;
	logic [7:0] c;

	function automatic logic [P-1:0] sat_inc(input logic [P-1:0] v);
		return (&v) ? v : v + P'(1);
	endfunction

	always_comb begin
		c = text_byte;
		mode_d = mode_q;
		tso_d = tso_q;
		tsl_d = tsl_q;
		tsc_d = tsc_q;
		plen_d = plen_q;
		boff_d = boff_q;
		line_d = line_q;
		col_d = col_q;
		has_a = 1'b0;
		has_b = 1'b0;
		used = 1'b0;
		op_mode = (mode_q >= M_OP) && (mode_q <= M_OP + MODE_W'(OP_N - 1));
		oi = 3'(mode_q - M_OP);

		ta = '0;
		ta.start = tso_q;
		ta.line = tsl_q;
		ta.col = tsc_q;
		ta.len = plen_q;
		tb = '0;
		tb.start = boff_q;
		tb.line = line_q;
		tb.col = col_q;
		tb.len = P'(1);

		if (end_of_text) begin
			if (mode_q == M_IDENT) begin
				has_a = 1'b1;
				ta.kind = K_IDENT;
			end else if (mode_q == M_NUM) begin
				has_a = 1'b1;
				ta.kind = K_INT;
			end else if (mode_q == M_STR || mode_q == M_ESC) begin
				has_a = 1'b1;
				ta.kind = K_ILLEGAL;
				ta.err = E_OPEN_STRING;
			end else if (op_mode) begin
				has_a = 1'b1;
				ta.kind = op_single(oi);
				ta.len = P'(1);
			end
			has_b = 1'b1;
			tb.kind = K_END;
			tb.len = '0;
			mode_d = M_IDLE;
			tso_d = '0;
			tsl_d = P'(1);
			tsc_d = P'(1);
			plen_d = '0;
			boff_d = '0;
			line_d = P'(1);
			col_d = P'(1);
		end else begin
			if (mode_q == M_IDENT) begin
				if (is_letter(c) || is_digit(c)) begin
					plen_d = sat_inc(plen_q);
					used = 1'b1;
				end else begin
					has_a = 1'b1;
					ta.kind = K_IDENT;
					ta.opt = (c == CH_QMARK);
					used = (c == CH_QMARK);
					mode_d = M_IDLE;
				end
			end else if (mode_q == M_NUM) begin
				if (is_digit(c)) begin
					plen_d = sat_inc(plen_q);
					used = 1'b1;
				end else begin
					has_a = 1'b1;
					ta.kind = K_INT;
					mode_d = M_IDLE;
				end
			end else if (mode_q == M_STR) begin
				used = 1'b1;
				if (c == CH_QUOTE) begin
					has_a = 1'b1;
					ta.kind = K_STRING;
					mode_d = M_IDLE;
				end else begin
					plen_d = sat_inc(plen_q);
					if (c == CH_BSLASH) begin
						mode_d = M_ESC;
					end
				end
			end else if (mode_q == M_ESC) begin
				used = 1'b1;
				plen_d = sat_inc(plen_q);
				mode_d = M_STR;
			end else if (op_mode) begin
				has_a = 1'b1;
				ta.len = P'(2);
				if (c == op_second(oi)) begin
					ta.kind = op_double(oi);
					used = 1'b1;
				end else if (oi == OPI_EQUAL && c == CH_GT) begin
					ta.kind = K_ARROW;
					used = 1'b1;
				end else begin
					ta.kind = op_single(oi);
					ta.len = P'(1);
				end
				mode_d = M_IDLE;
			end else begin
				mode_d = M_IDLE;
			end

			if (!used) begin
				tso_d = boff_q;
				tsl_d = line_q;
				tsc_d = col_q;
				plen_d = '0;
				if (is_op_first(c)) begin
					mode_d = M_OP + MODE_W'(op_index(c));
					plen_d = P'(1);
				end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
					has_b = 1'b0;
				end else if (c == CH_LF) begin
					has_b = 1'b1;
					tb.kind = K_NEWLINE;
				end else if (single_kind(c) != K_ILLEGAL) begin
					has_b = 1'b1;
					tb.kind = single_kind(c);
				end else if (c == CH_QUOTE) begin
					tso_d = sat_inc(boff_q);
					mode_d = M_STR;
				end else if (is_letter(c)) begin
					plen_d = P'(1);
					mode_d = M_IDENT;
				end else if (is_digit(c)) begin
					plen_d = P'(1);
					mode_d = M_NUM;
				end else begin
					has_b = 1'b1;
					tb.kind = K_ILLEGAL;
					tb.err = E_ILLEGAL;
				end
			end

			boff_d = sat_inc(boff_q);
			if (c == CH_LF) begin
				line_d = sat_inc(line_q);
				col_d = P'(1);
			end else begin
				col_d = sat_inc(col_q);
			end
		end

		t0 = has_a ? ta : tb;
		t0.last = !(has_a && has_b);
		t1 = tb;
		t1.last = 1'b1;
	end

	assign tok0 = t0;
	assign tok1 = t1;
	assign tok_count = {1'b0, has_a} + {1'b0, has_b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			tso_q <= '0;
			tsl_q <= P'(1);
			tsc_q <= P'(1);
			plen_q <= '0;
			boff_q <= '0;
			line_q <= P'(1);
			col_q <= P'(1);
		end else if (step) begin
			mode_q <= mode_d;
			tso_q <= tso_d;
			tsl_q <= tsl_d;
			tsc_q <= tsc_d;
			plen_q <= plen_d;
			boff_q <= boff_d;
			line_q <= line_d;
			col_q <= col_d;
		end
	end

endmodule

`default_nettype wire

FILE: sv/expression_language_tokenizer.sv
// Channel  Dir  Word                                  Marker / side band
// s_*      in   tdata: text_byte[7:0]                 tlast: end_of_text
// m_*      out  tdata: start, length, line, column    tuser: kind, option, error;
//                                                     tlast: last token of the input word
// An input word is registered in the input register, decoded combinationally by the lexer and
// its tokens are registered into a two-entry result buffer, from which they are offered.
// One input word per cycle is sustained while each word yields at most one token and
// m_tready stays high; after a word that yields two tokens the next word waits in the
// input register until a token leaves, since the buffer drains at most one token per cycle.
// arst_n clears the lexer state and empties the input register and the result buffer.
// A stall on m_tready reaches s_tready once a stuck token blocks a word in the input register.
`default_nettype none

module expression_language_tokenizer
	import elt_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEF,
	localparam int TdataW = ((4 * POSITION_BITS + 7) / 8) * 8,
	localparam int TuserW = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [7:0]        s_tdata,   // text_byte
	input  wire logic              s_tlast,   // end_of_text
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [TdataW-1:0] m_tdata,   // start_offset, token_length, token_line,
	                                          // token_column, zero fill
	output logic      [TuserW-1:0] m_tuser,   // token_kind, option_mark, error_code, zero fill
	output logic                   m_tlast    // last_of_run
);

	localparam int P = POSITION_BITS;
	localparam int TokW = 4 * P + KIND_W + ERR_W + 2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [P-1:0]      start;
		logic [P-1:0]      len;
		logic [P-1:0]      line;
		logic [P-1:0]      col;
		logic              opt;
		logic [ERR_W-1:0]  err;
		logic              last;
	} tok_t;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;

	logic [TokW-1:0] tok0, tok1;
	logic [1:0]      tok_count;
	logic [1:0]      cnt_q;
	tok_t            outa_q, outb_q;
	logic            pop, out_free, proc, accept;

	assign pop = (cnt_q != 2'd0) && m_tready;
	assign out_free = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_tready);
	assign proc = valid_s1 && out_free;
	assign s_tready = !valid_s1 || proc;
	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= s_tdata;
			eot_s1 <= s_tlast;
		end
	end

	elt_lexer #(
		.POSITION_BITS(P)
	) u_lexer (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (proc),
		.text_byte  (byte_s1),
		.end_of_text(eot_s1),
		.tok0       (tok0),
		.tok1       (tok1),
		.tok_count  (tok_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (proc) begin
			cnt_q <= tok_count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			outa_q <= tok0;
			outb_q <= tok1;
		end else if (pop) begin
			outa_q <= outb_q;
		end
	end

	assign m_tvalid = cnt_q != 2'd0;
	assign m_tdata = TdataW'({outa_q.col, outa_q.line, outa_q.len, outa_q.start});
	assign m_tuser = TuserW'({outa_q.err, outa_q.opt, outa_q.kind});
	assign m_tlast = outa_q.last;

endmodule

`default_nettype wire

FILE: sv/elt_checker.sv
`default_nettype none

module elt_checker
	import elt_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEF,
	localparam int TdataW = ((4 * POSITION_BITS + 7) / 8) * 8,
	localparam int TuserW = 16
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              m_tvalid,
	input wire logic              m_tready,
	input wire logic [TdataW-1:0] m_tdata,
	input wire logic [TuserW-1:0] m_tuser,
	input wire logic              m_tlast
);

	logic [KIND_W-1:0] kind;
	logic              opt;
	logic [ERR_W-1:0]  err;

	assign kind = m_tuser[KIND_W-1:0];
	assign opt = m_tuser[KIND_W];
	assign err = m_tuser[KIND_W+ERR_W:KIND_W+1];

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word withdrawn while stalled");

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("output word changed while stalled");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && kind == K_END |-> m_tlast && m_tdata[2*POSITION_BITS-1:POSITION_BITS] == '0)
		else $error("end token is not the last word or has a length");

	a_open_string: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && err == E_OPEN_STRING |-> kind == K_ILLEGAL && !m_tlast)
		else $error("open string error not followed by the end token");

	a_option_ident: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && opt |-> kind == K_IDENT && err == E_NONE)
		else $error("option mark on a token that is not an identifier");

endmodule

bind expression_language_tokenizer elt_checker #(
	.POSITION_BITS(POSITION_BITS)
) u_elt_checker (.*);

`default_nettype wire
